// ===== hdl/lpe_pkg.sv =====
// Package with the shared types, widths and constants of the line position estimator.
`timescale 1ns / 1ps
package lpe_pkg;

    localparam int NUM_CHANNELS = 6;
    localparam int RAW_W        = 10;
    localparam int LEVEL_W      = 10;
    localparam int TABLE_W      = 60;
    localparam int CFG_IDX_W    = 2;
    localparam int FULL_SCALE   = 1000;

    // Calibration divide: magnitude of (raw - min) * 1000 and a 10-bit quotient.
    localparam int NUM_W     = 20;
    localparam int CAL_STEPS = 10;

    // Position divide: weighted sum over total, quotient up to 5000.
    localparam int POS_W      = 13;
    localparam int WPROD_W    = 23;
    localparam int WSUM_W     = 24;
    localparam int TOT_W      = 13;
    localparam int BDIV_STEPS = 13;

    localparam logic [POS_W-1:0] LOST_POS = POS_W'(NUM_CHANNELS * FULL_SCALE);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRACK = 2'd0,
        REG_NOISE = 2'd1,
        REG_MIN   = 2'd2,
        REG_MAX   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] track_level;
        logic [LEVEL_W-1:0] noise_level;
        logic [TABLE_W-1:0] min_table;
        logic [TABLE_W-1:0] max_table;
    } lpe_cfg_t;

    typedef struct packed {
        logic [WSUM_W-1:0] weighted;
        logic [TOT_W-1:0]  total;
        logic              present;
    } lpe_sum_t;

    function automatic logic [POS_W-1:0] chan_weight(input int ch);
        return POS_W'(ch * FULL_SCALE);
    endfunction

endpackage

// ===== hdl/lpe_if.sv =====
// Valid/ready interfaces for the frame input and the position result.
`timescale 1ns / 1ps
interface lpe_frame_if import lpe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_zero;
    logic [RAW_W-1:0] raw_one;
    logic [RAW_W-1:0] raw_two;
    logic [RAW_W-1:0] raw_three;
    logic [RAW_W-1:0] raw_four;
    logic [RAW_W-1:0] raw_five;

    modport source (output valid, raw_zero, raw_one, raw_two, raw_three, raw_four, raw_five,
                    input ready);
    modport sink (input valid, raw_zero, raw_one, raw_two, raw_three, raw_four, raw_five,
                  output ready);
endinterface

interface lpe_result_if import lpe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic             online;

    modport source (output valid, position, online, input ready);
    modport sink (input valid, position, online, output ready);
endinterface

// ===== hdl/line_position_estimator_top.sv =====
// Top level of the line position estimator: configuration registers, front, queue and back.
//
//   Port group   Direction  Contents
//   frame        in         valid/ready, raw_zero .. raw_five (10 bits each)
//   result       out        valid/ready, position (13 bits), online
//   cfg_*        in         cfg_we, cfg_index (2 bits), cfg_data (60 bits)
//
// One frame is accepted per cycle when nothing stalls.
// An item passes through the calibration front, the queue and the position divider in turn;
// both dividers resolve one quotient bit per pipeline stage.
// Reset clears all valid bits and loads the register defaults; there is no clearing pass.
// A stalled result holds the back end, while the front keeps accepting until the queue fills.
`timescale 1ns / 1ps
module line_position_estimator_top import lpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TABLE_W-1:0]   cfg_data,
    lpe_frame_if.sink            frame,
    lpe_result_if.source         result
);

    lpe_cfg_t cfg_reg;
    logic     push_valid;
    logic     push_ready;
    lpe_sum_t push_data;
    logic     pop_valid;
    logic     pop_ready;
    lpe_sum_t pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.track_level <= LEVEL_W'(500);
            cfg_reg.noise_level <= LEVEL_W'(50);
            cfg_reg.min_table   <= '0;
            cfg_reg.max_table   <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TRACK: cfg_reg.track_level <= cfg_data[LEVEL_W-1:0];
                REG_NOISE: cfg_reg.noise_level <= cfg_data[LEVEL_W-1:0];
                REG_MIN:   cfg_reg.min_table   <= cfg_data;
                REG_MAX:   cfg_reg.max_table   <= cfg_data;
                default:   ;
            endcase
        end
    end

    lpe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .frame      (frame),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lpe_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lpe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

// ===== hdl/lpe_front.sv =====
// Front pipeline: per-channel calibration, thresholding and weighted sums.
`timescale 1ns / 1ps
module lpe_front import lpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lpe_cfg_t    cfg,
    lpe_frame_if.sink   frame,
    output logic        push_valid,
    input  logic        push_ready,
    output lpe_sum_t    push_data
);

    localparam int NST = CAL_STEPS + 3;

    logic [NST-1:0] vld_reg;
    logic           en;

    logic [RAW_W-1:0]   raw     [6];
    logic [RAW_W:0]     diff_n  [NUM_CHANNELS];
    logic [RAW_W:0]     diff_d  [NUM_CHANNELS];
    logic [RAW_W:0]     abs_n   [NUM_CHANNELS];
    logic [RAW_W:0]     abs_d   [NUM_CHANNELS];
    logic [NUM_W-1:0]   num_c   [NUM_CHANNELS];
    logic [NUM_W:0]     lim_c   [NUM_CHANNELS];
    logic               zero_c  [NUM_CHANNELS];
    logic               ovf_c   [NUM_CHANNELS];

    logic [NUM_W-1:0]     rem_reg  [CAL_STEPS+1][NUM_CHANNELS];
    logic [CAL_STEPS-1:0] quo_reg  [CAL_STEPS+1][NUM_CHANNELS];
    logic [RAW_W-1:0]     den_reg  [CAL_STEPS+1][NUM_CHANNELS];
    logic                 zero_reg [CAL_STEPS+1][NUM_CHANNELS];
    logic                 ovf_reg  [CAL_STEPS+1][NUM_CHANNELS];
    logic [NUM_W-1:0]     trial    [CAL_STEPS+1][NUM_CHANNELS];

    logic [LEVEL_W-1:0]   cal_v    [NUM_CHANNELS];
    logic [WPROD_W-1:0]   prod_reg [NUM_CHANNELS];
    logic [TOT_W-1:0]     part_reg [NUM_CHANNELS];
    logic                 hit_reg;
    logic                 hit_c;

    lpe_sum_t sum_reg;
    lpe_sum_t sum_next;

    // The whole pipeline moves together unless the last stage holds an item the queue refuses.
    assign en          = !vld_reg[NST-1] || push_ready;
    assign frame.ready = en;
    assign push_valid  = vld_reg[NST-1];
    assign push_data   = sum_reg;

    assign raw[0] = frame.raw_zero;
    assign raw[1] = frame.raw_one;
    assign raw[2] = frame.raw_two;
    assign raw[3] = frame.raw_three;
    assign raw[4] = frame.raw_four;
    assign raw[5] = frame.raw_five;

    // Signs are split off so the divide runs on magnitudes; a negative quotient clamps to zero.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            diff_n[ch] = {1'b0, raw[ch]} - {1'b0, cfg.min_table[ch*RAW_W +: RAW_W]};
            diff_d[ch] = {1'b0, cfg.max_table[ch*RAW_W +: RAW_W]}
                         - {1'b0, cfg.min_table[ch*RAW_W +: RAW_W]};
            abs_n[ch]  = diff_n[ch][RAW_W] ? (~diff_n[ch] + 1'b1) : diff_n[ch];
            abs_d[ch]  = diff_d[ch][RAW_W] ? (~diff_d[ch] + 1'b1) : diff_d[ch];
            num_c[ch]  = NUM_W'(abs_n[ch]) * NUM_W'(FULL_SCALE);
            lim_c[ch]  = (NUM_W+1)'(abs_d[ch]) * (NUM_W+1)'(FULL_SCALE + 1);
            ovf_c[ch]  = {1'b0, num_c[ch]} >= lim_c[ch];
            zero_c[ch] = (diff_d[ch] == '0) || (diff_n[ch] == '0)
                         || (diff_n[ch][RAW_W] != diff_d[ch][RAW_W]);
        end
    end

    always_comb
    begin
        for (int s = 0; s <= CAL_STEPS; s++)
        begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                trial[s][ch] = (s == 0) ? '0
                               : (NUM_W'(den_reg[s-1][ch]) << (CAL_STEPS - s));
            end
        end
    end

    always_comb
    begin
        hit_c = 1'b0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            cal_v[ch] = zero_reg[CAL_STEPS][ch] ? '0
                        : ovf_reg[CAL_STEPS][ch] ? LEVEL_W'(FULL_SCALE)
                        : quo_reg[CAL_STEPS][ch];
            if (cal_v[ch] >= cfg.track_level)
            begin
                hit_c = 1'b1;
            end
        end
    end

    always_comb
    begin
        sum_next.weighted = '0;
        sum_next.total    = '0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            sum_next.weighted = sum_next.weighted + WSUM_W'(prod_reg[ch]);
            sum_next.total    = sum_next.total + part_reg[ch];
        end
        sum_next.present = hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], frame.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                rem_reg[0][ch]  <= num_c[ch];
                quo_reg[0][ch]  <= '0;
                den_reg[0][ch]  <= abs_d[ch][RAW_W-1:0];
                zero_reg[0][ch] <= zero_c[ch];
                ovf_reg[0][ch]  <= ovf_c[ch];
            end
            for (int s = 1; s <= CAL_STEPS; s++)
            begin
                for (int ch = 0; ch < NUM_CHANNELS; ch++)
                begin
                    if (rem_reg[s-1][ch] >= trial[s][ch])
                    begin
                        rem_reg[s][ch] <= rem_reg[s-1][ch] - trial[s][ch];
                        quo_reg[s][ch] <= quo_reg[s-1][ch]
                                          | (CAL_STEPS'(1) << (CAL_STEPS - s));
                    end
                    else
                    begin
                        rem_reg[s][ch] <= rem_reg[s-1][ch];
                        quo_reg[s][ch] <= quo_reg[s-1][ch];
                    end
                    den_reg[s][ch]  <= den_reg[s-1][ch];
                    zero_reg[s][ch] <= zero_reg[s-1][ch];
                    ovf_reg[s][ch]  <= ovf_reg[s-1][ch];
                end
            end
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                if (cal_v[ch] >= cfg.noise_level)
                begin
                    prod_reg[ch] <= WPROD_W'(cal_v[ch]) * WPROD_W'(chan_weight(ch));
                    part_reg[ch] <= TOT_W'(cal_v[ch]);
                end
                else
                begin
                    prod_reg[ch] <= '0;
                    part_reg[ch] <= '0;
                end
            end
            hit_reg <= hit_c;
            sum_reg <= sum_next;
        end
    end

endmodule

// ===== hdl/lpe_fifo.sv =====
// Two-entry queue between the calibration front and the position divider.
`timescale 1ns / 1ps
module lpe_fifo import lpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  lpe_sum_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output lpe_sum_t pop_data
);

    lpe_sum_t   mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/lpe_back.sv =====
// Back pipeline: restoring divide of weighted sum by total, one quotient bit per stage.
`timescale 1ns / 1ps
module lpe_back import lpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  lpe_sum_t    pop_data,
    lpe_result_if.source result
);

    localparam int NSB = BDIV_STEPS + 1;

    logic [NSB-1:0]        vld_reg;
    logic                  en;
    logic [WSUM_W-1:0]     rem_reg [NSB];
    logic [POS_W-1:0]      quo_reg [NSB];
    logic [TOT_W-1:0]      den_reg [NSB];
    logic                  ok_reg  [NSB];
    logic [WSUM_W:0]       trial   [NSB];

    assign en            = !vld_reg[NSB-1] || result.ready;
    assign pop_ready     = en;
    assign result.valid  = vld_reg[NSB-1];
    assign result.online = ok_reg[NSB-1];
    assign result.position = ok_reg[NSB-1] ? quo_reg[NSB-1] : LOST_POS;

    always_comb
    begin
        for (int s = 0; s < NSB; s++)
        begin
            trial[s] = (s == 0) ? '0 : ((WSUM_W+1)'(den_reg[s-1]) << (BDIV_STEPS - s));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSB-2:0], pop_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= pop_data.weighted;
            quo_reg[0] <= '0;
            den_reg[0] <= pop_data.total;
            ok_reg[0]  <= pop_data.present && (pop_data.total != '0);
            for (int s = 1; s < NSB; s++)
            begin
                if ({1'b0, rem_reg[s-1]} >= trial[s])
                begin
                    rem_reg[s] <= WSUM_W'({1'b0, rem_reg[s-1]} - trial[s]);
                    quo_reg[s] <= quo_reg[s-1] | (POS_W'(1) << (BDIV_STEPS - s));
                end
                else
                begin
                    rem_reg[s] <= rem_reg[s-1];
                    quo_reg[s] <= quo_reg[s-1];
                end
                den_reg[s] <= den_reg[s-1];
                ok_reg[s]  <= ok_reg[s-1];
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the line position estimator: frames in, positions checked.
`timescale 1ns / 1ps
module testbench;
    import lpe_pkg::*;

    typedef struct packed {
        logic [RAW_W-1:0] r5;
        logic [RAW_W-1:0] r4;
        logic [RAW_W-1:0] r3;
        logic [RAW_W-1:0] r2;
        logic [RAW_W-1:0] r1;
        logic [RAW_W-1:0] r0;
    } frame_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             online;
    } position_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TABLE_W-1:0] cfg_data;

    lpe_frame_if frame ();
    lpe_result_if result ();

    line_position_estimator_top i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .frame(frame.sink), .result(result.source)
    );

    logic [LEVEL_W-1:0] track_lvl;
    logic [LEVEL_W-1:0] noise_lvl;
    logic [TABLE_W-1:0] min_tbl;
    logic [TABLE_W-1:0] max_tbl;

    frame_t pending_frames[$];
    position_t expected_positions[$];
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_result;
    int stall_count;
    int errors;
    int checked;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int calibrate_level(int raw, int mn, int mx);
        int q;
        if (mx == mn)
            return 0;
        q = ((raw - mn) * FULL_SCALE) / (mx - mn);   // SV int division truncates toward zero
        if (q < 0)
            q = 0;
        if (q > FULL_SCALE)
            q = FULL_SCALE;
        return q;
    endfunction

    function automatic position_t estimate_position(frame_t f);
        position_t p;
        logic [RAW_W-1:0] raws[NUM_CHANNELS];
        bit present;
        longint weighted;
        longint total;
        int v;
        raws = '{f.r0, f.r1, f.r2, f.r3, f.r4, f.r5};
        present = 0;
        weighted = 0;
        total = 0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            v = calibrate_level(int'(raws[i]), int'(min_tbl[10*i +: 10]),
                                int'(max_tbl[10*i +: 10]));
            if (v >= int'(track_lvl))
                present = 1;
            if (v >= int'(noise_lvl))
            begin
                weighted += longint'(v) * i * FULL_SCALE;
                total += v;
            end
        end
        if (present && total != 0)
        begin
            p.position = POS_W'(weighted / total);
            p.online = 1'b1;
        end
        else
        begin
            p.position = POS_W'(NUM_CHANNELS * FULL_SCALE);
            p.online = 1'b0;
        end
        return p;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want, checked);
        errors++;
    endtask

    // Driver: holds an item until it is accepted, then takes the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame.valid <= 1'b0;
            {frame.raw_five, frame.raw_four, frame.raw_three, frame.raw_two,
             frame.raw_one, frame.raw_zero} <= '0;
        end
        else
        begin
            if (frame.valid && frame.ready)
            begin
                expected_positions.push_back(estimate_position(
                    {frame.raw_five, frame.raw_four, frame.raw_three, frame.raw_two,
                     frame.raw_one, frame.raw_zero}));
            end
            if (!frame.valid || frame.ready)
            begin
                if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    frame_t f;
                    f = pending_frames.pop_front();
                    frame.valid <= 1'b1;
                    {frame.raw_five, frame.raw_four, frame.raw_three, frame.raw_two,
                     frame.raw_one, frame.raw_zero} <= f;
                end
                else
                    frame.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= !hold_result && ($urandom_range(99) >= recv_idle_pct);
    end

    // Counts the cycles of a long result stall and lifts it when the stretch is over.
    always @(posedge clk)
    begin
        if (hold_result)
        begin
            stall_count++;
            if (stall_count >= STALL_CYCLES)
            begin
                hold_result = 0;
                stall_count = 0;
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_positions.size() == 0)
            begin
                report_mismatch("unexpected result", int'(result.position), -1);
            end
            else
            begin
                position_t e;
                e = expected_positions.pop_front();
                if (result.position !== e.position)
                    report_mismatch("position", int'(result.position), int'(e.position));
                if (result.online !== e.online)
                    report_mismatch("online", int'(result.online), int'(e.online));
            end
            checked++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[line_position_estimator_top] ERROR");
            $finish;
        end
    end

    task automatic write_register(cfg_reg_t idx, logic [TABLE_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TRACK: track_lvl = data[LEVEL_W-1:0];
            REG_NOISE: noise_lvl = data[LEVEL_W-1:0];
            REG_MIN:   min_tbl = data;
            REG_MAX:   max_tbl = data;
            default:   ;
        endcase
    endtask

    // Sampled at the falling edge so the driver's updates of the same rising edge are settled.
    task automatic wait_until_drained();
        @(negedge clk);
        while (pending_frames.size() > 0 || frame.valid || expected_positions.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic [LEVEL_W-1:0] trk, logic [LEVEL_W-1:0] noi,
                              logic [TABLE_W-1:0] mn, logic [TABLE_W-1:0] mx);
        wait_until_drained();
        write_register(REG_TRACK, TABLE_W'(trk));
        write_register(REG_NOISE, TABLE_W'(noi));
        write_register(REG_MIN, mn);
        write_register(REG_MAX, mx);
    endtask

    function automatic logic [TABLE_W-1:0] random_table(int lo, int hi);
        logic [TABLE_W-1:0] t;
        for (int i = 0; i < NUM_CHANNELS; i++)
            t[10*i +: 10] = 10'($urandom_range(hi, lo));
        return t;
    endfunction

    function automatic frame_t random_frame(int mode);
        frame_t f;
        f = 60'({$urandom, $urandom});
        // Mostly a line under one or two adjacent sensors on a dark background.
        if (mode < 7)
        begin
            int c;
            c = $urandom_range(NUM_CHANNELS - 1);
            f = '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
                f[10*i +: 10] = 10'($urandom_range(200));
            f[10*c +: 10] = 10'($urandom_range(1023, 500));
            if (c < NUM_CHANNELS - 1)
                f[10*(c+1) +: 10] = 10'($urandom_range(1023));
        end
        return f;
    endfunction

    task automatic queue_random(int n);
        for (int k = 0; k < n; k++)
            pending_frames.push_back(random_frame($urandom_range(9)));
    endtask

    initial
    begin
        frame_t f;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TRACK;
        cfg_data = '0;
        hold_result = 0;
        stall_count = 0;
        errors = 0;
        checked = 0;
        cycles = 0;
        send_idle_pct = 11;
        recv_idle_pct = 60;
        track_lvl = 10'd500;
        noise_lvl = 10'd50;
        min_tbl = '0;
        max_tbl = {TABLE_W{1'b1}};
        repeat (10) @(posedge clk);
        rst_n = 1'b1;

        // Directed frames under the reset calibration.
        pending_frames.push_back('0);
        pending_frames.push_back('1);
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            f = '0;
            f[10*i +: 10] = 10'h3FF;
            pending_frames.push_back(f);
        end
        pending_frames.push_back({6{10'd30}});
        pending_frames.push_back({10'd0, 10'd0, 10'd0, 10'd0, 10'd600, 10'd30});
        pending_frames.push_back({6{10'h155}});
        pending_frames.push_back({6{10'h2AA}});

        // Equal bounds on some channels, inverted bounds on others, extremes of levels.
        set_config(10'd0, 10'd0, {10'd5, 10'd900, 10'd0, 10'd100, 10'd1023, 10'd0},
                   {10'd5, 10'd100, 10'd1023, 10'd100, 10'd0, 10'd1023});
        pending_frames.push_back('0);
        pending_frames.push_back('1);
        pending_frames.push_back({6{10'd500}});
        pending_frames.push_back({10'd5, 10'd50, 10'd1023, 10'd3, 10'd511, 10'd0});
        set_config(10'd1023, 10'd1023, '0, '1);
        pending_frames.push_back('1);
        pending_frames.push_back({6{10'd700}});
        set_config(10'd1000, 10'd1000, '0, {6{10'd1000}});
        pending_frames.push_back('1);
        pending_frames.push_back({10'd1000, 10'd999, 10'd0, 10'd0, 10'd0, 10'd1000});
        set_config(10'd500, 10'd1001, '0, '1);
        pending_frames.push_back('1);

        // Random part over several settings and idling profiles.
        set_config(10'd500, 10'd50, random_table(0, 150), random_table(700, 1023));
        queue_random(120);
        set_config(LEVEL_W'($urandom_range(1000)), LEVEL_W'($urandom_range(300)),
                   random_table(0, 1023), random_table(0, 1023));
        queue_random(60);
        wait_until_drained();
        send_idle_pct = 60;
        recv_idle_pct = 11;
        set_config(10'd300, 10'd100, random_table(0, 300), random_table(600, 1023));
        queue_random(120);

        // Long result stall while frames keep coming, so the input backs up.
        wait_until_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(80);
        hold_result = 1;
        wait (!hold_result);
        set_config(10'd700, 10'd0, random_table(0, 1023), random_table(0, 1023));
        queue_random(60);

        wait_until_drained();
        $display("covered directed edge frames, equal and inverted bounds, level extremes,");
        $display("and %0d checked results under several idling profiles and a long stall",
                 checked);
        if (errors == 0)
            $display("[line_position_estimator_top] OK");
        else
            $display("[line_position_estimator_top] ERROR");
        $finish;
    end
endmodule
